### rtl/sliding_window_median_top_assert.svh
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// Implication or plain property, checked on clk, off during reset.
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge out of reset.
`define SWM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/swm_pkg.sv
// Package: sizes, types and helpers of the sliding window median filter.
package swm_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W       = IDX_W;

    localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(8);
    localparam logic [CNT_W-1:0] WIN_FULL  = CNT_W'(WINDOW_MAX);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One cell's contents, plus its compare flag against the incoming sample
    typedef struct packed {
        sample_t            value;
        logic [AGE_W-1:0]   age;
        logic               valid;
        logic               gt;     // empty, or holds a value above the sample
    } cell_view_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic               step;      // sample beat taken this cycle
        logic               clear;     // window reconfigured, drop everything
        logic               evict;     // window full, oldest leaves
        logic [AGE_W-1:0]   age_last;  // age of the oldest entry (window - 1)
        sample_t            sample;
    } cell_ctl_t;

    // Window register write: zero acts as one, large values saturate
    function automatic logic [CNT_W-1:0] clamp_window(input logic [5:0] v);
        logic [CNT_W-1:0] r;
        if (v == 6'd0)
            r = CNT_W'(1);
        else if ({1'b0, v} > 7'(WINDOW_MAX))
            r = WIN_FULL;
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

### rtl/swm_ifs.sv
// Valid/ready stream interfaces for samples and median results.
interface swm_sample_if
    import swm_pkg::*;
    ();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_result_if
    import swm_pkg::*;
    ();
    logic    valid;
    logic    ready;
    sample_t median;
    logic    ready_res;

    modport source (output valid, output median, output ready_res, input ready);
    modport sink   (input valid, input median, input ready_res, output ready);
endinterface

### rtl/sliding_window_median_top.sv
// Top level: sliding window median filter over a chain of sorted cells.
// Path: an accepted sample beat is stored by the cell update, then its median is
// picked into the output register once that register is free.
// Throughput: one sample per cycle while the result output does not stall; the whole cell chain updates at once.
// Reset empties the window and sets the window size to 8; a window write also
// empties it. No clearing pass: valid bits reset at once.
module sliding_window_median_top
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    swm_sample_if.sink  samples,
    swm_result_if.source results
);

    `include "sliding_window_median_top_assert.svh"

    logic [CNT_W-1:0] window_reg, window_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;
    logic             pend_full_reg, pend_full_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          median_reg, median_next;
    logic             ready_res_reg, ready_res_next;

    logic             in_acc, stage2_go, evict;
    cell_ctl_t        ctl;
    cell_view_t       raw  [WINDOW_MAX];
    cell_view_t       view [WINDOW_MAX];
    logic             shl  [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0] valid_vec;
    logic [IDX_W-1:0] mid_idx;

    // Handshake: result moves on when the output register is free
    assign stage2_go     = pend_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !pend_reg || stage2_go;
    assign in_acc        = samples.valid && samples.ready;
    assign evict         = (fill_reg >= window_reg);

    // Broadcast to the chain
    always_comb
    begin
        ctl.step     = in_acc;
        ctl.clear    = cfg_we;
        ctl.evict    = evict;
        ctl.age_last = AGE_W'(window_reg - CNT_W'(1));
        ctl.sample   = samples.sample;
    end

    // Cell chain
    assign shl[0] = 1'b0;
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_view_t lv, rr;
        if (i == 0)
        begin : g_first
            assign lv = '{value: '0, age: '0, valid: 1'b0, gt: 1'b0};
        end
        else
        begin : g_mid_l
            assign lv = view[i-1];
        end
        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign rr = '{value: '0, age: '0, valid: 1'b0, gt: 1'b1};
        end
        else
        begin : g_mid_r
            assign rr = raw[i+1];
        end
        swm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_view (lv),
            .right_raw (rr),
            .shl_in    (shl[i]),
            .raw       (raw[i]),
            .view      (view[i]),
            .shl_out   (shl[i+1])
        );
        assign valid_vec[i] = raw[i].valid;
    end

    // Window register, fill count and pending result
    always_comb
    begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        pend_full_next = pend_full_reg;
        if (cfg_we)
        begin
            window_next = clamp_window(cfg_wdata);
            fill_next   = '0;
        end
        else if (in_acc)
        begin
            fill_next = evict ? fill_reg : fill_reg + CNT_W'(1);
        end
        if (in_acc)
        begin
            pend_next      = 1'b1;
            pend_full_next = (evict ? fill_reg : fill_reg + CNT_W'(1)) == window_reg;
        end
        else if (stage2_go)
        begin
            pend_next = 1'b0;
        end
    end

    // Median pick into the output register (zero while the window is not yet full)
    assign mid_idx = window_reg[IDX_W:1];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        ready_res_next = ready_res_reg;
        if (stage2_go)
        begin
            out_valid_next = 1'b1;
            median_next    = pend_full_reg ? raw[mid_idx].value : '0;
            ready_res_next = pend_full_reg;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WIN_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_full_reg <= pend_full_next;
        median_reg    <= median_next;
        ready_res_reg <= ready_res_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.median    = median_reg;
    assign results.ready_res = ready_res_reg;

    // Checks
    `SWM_NEVER(a_fill_le_window, fill_reg > window_reg, "fill count exceeds window")
    `SWM_ASSERT(a_valid_matches_fill, $countones(valid_vec) == 32'(fill_reg), "valid cells != fill count")
    `SWM_ASSERT(a_full_stays_full, in_acc && !cfg_we && evict |=> fill_reg == $past(fill_reg), "full window changed size on insert")
    `SWM_NEVER(a_stall_blocks_input, pend_reg && out_valid_reg && !results.ready && samples.ready, "input taken while result stalled")

endmodule

### rtl/swm_cell.sv
// One cell of the sorted chain: holds a sample and its age, shifts left or right.
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  cell_view_t left_view,   // left neighbor after eviction
    input  cell_view_t right_raw,   // right neighbor as stored
    input  logic       shl_in,      // eviction happened further left
    output cell_view_t raw,
    output cell_view_t view,
    output logic       shl_out
);

    sample_t          value_reg, value_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             valid_reg, valid_next;
    logic             rm;

    // Own contents and compare against the incoming sample
    always_comb
    begin
        raw.value = value_reg;
        raw.age   = age_reg;
        raw.valid = valid_reg;
        raw.gt    = !valid_reg || (value_reg > ctl.sample);
    end

    // This cell holds the oldest sample and it leaves
    assign rm      = ctl.evict && valid_reg && (age_reg == ctl.age_last);
    assign shl_out = shl_in || rm;

    // Contents once the eviction gap is closed
    assign view = shl_out ? right_raw : raw;

    // Insertion: keep, take the new sample, or take the left neighbor
    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.step)
        begin
            if (!view.gt)
            begin
                value_next = view.value;
                age_next   = view.age + AGE_W'(1);
                valid_next = view.valid;
            end
            else if (!left_view.gt)
            begin
                value_next = ctl.sample;
                age_next   = '0;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = left_view.value;
                age_next   = left_view.age + AGE_W'(1);
                valid_next = left_view.valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            age_reg   <= age_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
